[rtl/wmnc_pkg.sv]
// ---------------------------------------------------------------------------
// World matrix normal classifier package
// Shared constants, the class encoding and the status word of the pipeline.
// ---------------------------------------------------------------------------
package wmnc_pkg;

    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    localparam int N_ENTRIES = 9;

    localparam int RATIO_W = 16;
    localparam int RATIO_FRAC = 8;
    localparam int QBITS = 16;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 16'd256;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;

    localparam int CLASS_W = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W = OUT_TDATA_W - CLASS_W - 1 - RATIO_W;

    typedef enum logic [CLASS_W-1:0] {
        CLS_UNIT       = 3'd0,
        CLS_UNIFORM    = 3'd1,
        CLS_NONUNIFORM = 3'd2,
        CLS_SKEW       = 3'd3,
        CLS_DEGENERATE = 3'd4
    } wmnc_class_t;

    typedef struct packed {
        logic        present;
        logic        mirrored;
        logic        saturate;
        wmnc_class_t world_class;
    } wmnc_status_t;

endpackage

[rtl/wmnc_front.sv]
// ---------------------------------------------------------------------------
// Front products
// Four stages: entry products, sums and cofactors, determinant terms and
// absolute dot products, determinant sign.
// ---------------------------------------------------------------------------
module wmnc_front
    import wmnc_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic                  in_present,
    input  logic [N_ENTRIES*W-1:0] in_flat,
    output logic                  out_present,
    output logic                  out_mirrored,
    output logic [2*W-1:0]        out_sumsq [3],
    output logic [2*W-1:0]        out_absdot [3]
);

    localparam int PW   = 2 * W;
    localparam int DOTW = 2 * W + 2;
    localparam int COFW = 2 * W + 1;
    localparam int TRMW = 3 * W + 1;
    localparam int DETW = 3 * W + 3;

    logic signed [W-1:0] e [N_ENTRIES];

    for (genvar k = 0; k < N_ENTRIES; k++) begin : g_ent
        assign e[k] = $signed(in_flat[k*W +: W]);
    end

    // Stage A
    logic signed [PW-1:0] sq_reg [N_ENTRIES];
    logic signed [PW-1:0] dp_reg [N_ENTRIES];
    logic signed [PW-1:0] cp_reg [6];
    logic signed [W-1:0]  r0a_reg [3];
    logic                 pa_reg;

    // Stage B
    logic [PW-1:0]          sumb_reg [3];
    logic signed [DOTW-1:0] dotb_reg [3];
    logic signed [COFW-1:0] cofb_reg [3];
    logic signed [W-1:0]    r0b_reg [3];
    logic                   pb_reg;

    // Stage C
    logic [PW-1:0]          sumc_reg [3];
    logic [PW-1:0]          absc_reg [3];
    logic signed [TRMW-1:0] trm_reg [3];
    logic                   pc_reg;

    // Stage D
    logic [PW-1:0] sumd_reg [3];
    logic [PW-1:0] absd_reg [3];
    logic          pd_reg;
    logic          mird_reg;

    logic signed [DETW-1:0] det;
    logic signed [DOTW-1:0] dneg [3];

    always_comb begin
        det = DETW'(trm_reg[0]) - DETW'(trm_reg[1]) + DETW'(trm_reg[2]);
        for (int p = 0; p < 3; p++) begin
            dneg[p] = -dotb_reg[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < N_ENTRIES; k++) begin
                sq_reg[k] <= e[k] * e[k];
            end
            for (int j = 0; j < 3; j++) begin
                dp_reg[j]     <= e[j] * e[3+j];
                dp_reg[3+j]   <= e[j] * e[6+j];
                dp_reg[6+j]   <= e[3+j] * e[6+j];
                r0a_reg[j]    <= e[j];
            end
            cp_reg[0] <= e[4] * e[8];
            cp_reg[1] <= e[5] * e[7];
            cp_reg[2] <= e[3] * e[8];
            cp_reg[3] <= e[5] * e[6];
            cp_reg[4] <= e[3] * e[7];
            cp_reg[5] <= e[4] * e[6];
            pa_reg <= in_present;

            for (int r = 0; r < 3; r++) begin
                sumb_reg[r] <= $unsigned(sq_reg[3*r]) + $unsigned(sq_reg[3*r+1])
                             + $unsigned(sq_reg[3*r+2]);
                dotb_reg[r] <= DOTW'(dp_reg[3*r]) + DOTW'(dp_reg[3*r+1])
                             + DOTW'(dp_reg[3*r+2]);
                cofb_reg[r] <= COFW'(cp_reg[2*r]) - COFW'(cp_reg[2*r+1]);
                r0b_reg[r]  <= r0a_reg[r];
            end
            pb_reg <= pa_reg;

            for (int r = 0; r < 3; r++) begin
                sumc_reg[r] <= sumb_reg[r];
                trm_reg[r]  <= r0b_reg[r] * cofb_reg[r];
                absc_reg[r] <= dotb_reg[r][DOTW-1] ? dneg[r][PW-1:0] : dotb_reg[r][PW-1:0];
            end
            pc_reg <= pb_reg;

            for (int r = 0; r < 3; r++) begin
                sumd_reg[r] <= sumc_reg[r];
                absd_reg[r] <= absc_reg[r];
            end
            pd_reg   <= pc_reg;
            mird_reg <= det[DETW-1];
        end
    end

    assign out_present  = pd_reg;
    assign out_mirrored = mird_reg;
    assign out_sumsq    = sumd_reg;
    assign out_absdot   = absd_reg;

endmodule

[rtl/wmnc_isqrt.sv]
// ---------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor of the square root of a 2W-bit value.
// ---------------------------------------------------------------------------
module wmnc_isqrt #(
    parameter int W = 16
) (
    input  logic           aclk,
    input  logic           ce,
    input  logic [2*W-1:0] in_value,
    output logic [W-1:0]   out_root
);

    logic [W-1:0]   rem_reg  [W-1];
    logic [2*W-1:0] x_reg    [W-1];
    logic [W-1:0]   root_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]   rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] x_in;
        logic [W+1:0]   cand;
        logic [W+1:0]   trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = in_value;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        assign cand  = {rem_in, x_in[2*W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (cand >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                root_reg[k] <= {root_in[W-2:0], ge};
            end
        end

        if (k < W - 1) begin : g_carry
            logic [W+1:0] diff;
            assign diff = ge ? (cand - trial) : cand;
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k] <= diff[W-1:0];
                    x_reg[k]   <= {x_in[2*W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_root = root_reg[W-1];

endmodule

[rtl/wmnc_div.sv]
// ---------------------------------------------------------------------------
// Pipelined ratio divider
// Restoring division of hi*256 by lo, one quotient bit per stage. The result
// is meaningful only when the quotient fits in QBITS bits.
// ---------------------------------------------------------------------------
module wmnc_div
    import wmnc_pkg::*;
#(
    parameter int W = 16
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [W-1:0]     in_hi,
    input  logic [W-1:0]     in_lo,
    output logic [QBITS-1:0] out_quot
);

    logic [W-1:0]     rem_reg  [QBITS-1];
    logic [W-1:0]     lo_reg   [QBITS-1];
    logic [QBITS-1:0] nlow_reg [QBITS-1];
    logic [QBITS-1:0] q_reg    [QBITS];

    logic [W-1:0]     rem_init;
    logic [QBITS-1:0] nlow_init;

    assign rem_init  = in_hi >> RATIO_FRAC;
    assign nlow_init = {in_hi[RATIO_FRAC-1:0], RATIO_FRAC'(0)};

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic [W-1:0]     rem_in;
        logic [W-1:0]     lo_in;
        logic [QBITS-1:0] nlow_in;
        logic [QBITS-1:0] q_in;
        logic [W:0]       cand;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = rem_init;
            assign lo_in   = in_lo;
            assign nlow_in = nlow_init;
            assign q_in    = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign lo_in   = lo_reg[k-1];
            assign nlow_in = nlow_reg[k-1];
            assign q_in    = q_reg[k-1];
        end

        assign cand = {rem_in, nlow_in[QBITS-1-k]};
        assign ge   = (cand >= {1'b0, lo_in});

        always_ff @(posedge aclk) begin
            if (ce) begin
                q_reg[k] <= {q_in[QBITS-2:0], ge};
            end
        end

        if (k < QBITS - 1) begin : g_carry
            logic [W:0] diff;
            assign diff = ge ? (cand - {1'b0, lo_in}) : cand;
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k]  <= diff[W-1:0];
                    lo_reg[k]   <= lo_in;
                    nlow_reg[k] <= nlow_in;
                end
            end
        end
    end

    assign out_quot = q_reg[QBITS-1];

endmodule

[rtl/world_matrix_normal_classifier_unit.sv]
// ---------------------------------------------------------------------------
// World matrix normal classifier
// Classifies the upper 3x3 of a world matrix as unit, uniform, nonuniform,
// skew or degenerate, and flags a negative determinant.
// ---------------------------------------------------------------------------
// Usage:
// A matrix enters as one beat on the s_ channel: the nine entries in s_tdata,
// row by row, and the matrix-present flag in s_tuser. One result beat leaves
// on the m_ channel for every input beat, in order.
// The tolerance register is written through the cfg_ channel, which is always
// ready. It is to be written only while no matrix is in flight.
// The pipeline holds four stages of products, one square-root stage per length
// bit, one stage of bounds, a sixteen-stage divider for the scale ratio and the
// output register. It takes one matrix per cycle while it is not stalled.
// The whole pipeline advances together. When the output beat is not taken,
// every stage holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the tolerance with 66.
// ---------------------------------------------------------------------------
module world_matrix_normal_classifier_unit
    import wmnc_pkg::*;
#(
    parameter int ENTRY_WIDTH   = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Tolerance register write.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TOL_W-1:0]         cfg_data,
    // Input beats.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
    // row2_x, row2_y, row2_z, then zero padding to whole bytes.
    input  logic [((N_ENTRIES*ENTRY_WIDTH+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0 up: matrix_present.
    input  logic [0:0]               s_tuser,
    // Result beats.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // Fields from bit 0 up: world_class, mirrored, scale_ratio, zero padding.
    output logic [OUT_TDATA_W-1:0]   m_tdata
);

    localparam int W     = ENTRY_WIDTH;
    localparam int FB    = FRACTION_BITS;
    localparam int DEPTH = W + 22;
    localparam int MXW   = (W > FB) ? W : FB + 1;
    localparam int DGW   = MXW + TOL_W;
    localparam int XW    = MXW + 1;
    localparam int UW    = XW + TOL_W;
    localparam int NW    = W + TOL_W;
    localparam int SW    = W + RATIO_FRAC;
    localparam int SKW   = 2 * W + TOL_W;

    // The pipeline moves as one whenever the output register is free or taken.
    logic             ce;
    logic [DEPTH-1:0] vld_reg;
    logic [TOL_W-1:0] tol_reg;

    assign ce        = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            tol_reg <= TOL_RESET;
        end else begin
            if (ce) begin
                vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
            end
            if (cfg_valid) begin
                tol_reg <= cfg_data;
            end
        end
    end

    // Squared row lengths, row dot products and the determinant sign.
    logic           f_present;
    logic           f_mirrored;
    logic [2*W-1:0] f_sumsq  [3];
    logic [2*W-1:0] f_absdot [3];

    wmnc_front #(.W(W)) u_front (
        .aclk        (aclk),
        .ce          (ce),
        .in_present  (s_tuser[0]),
        .in_flat     (s_tdata[N_ENTRIES*W-1:0]),
        .out_present (f_present),
        .out_mirrored(f_mirrored),
        .out_sumsq   (f_sumsq),
        .out_absdot  (f_absdot)
    );

    // Row lengths, one root pipeline per row.
    logic [W-1:0] len [3];

    for (genvar r = 0; r < 3; r++) begin : g_root
        wmnc_isqrt #(.W(W)) u_isqrt (
            .aclk    (aclk),
            .ce      (ce),
            .in_value(f_sumsq[r]),
            .out_root(len[r])
        );
    end

    // Side data waits alongside the root pipelines.
    logic [2*W-1:0] dot_dly_reg [W][3];
    logic [W-1:0]   pres_dly_reg;
    logic [W-1:0]   mir_dly_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dot_dly_reg[0] <= f_absdot;
            for (int d = 1; d < W; d++) begin
                dot_dly_reg[d] <= dot_dly_reg[d-1];
            end
            pres_dly_reg <= {pres_dly_reg[W-2:0], f_present};
            mir_dly_reg  <= {mir_dly_reg[W-2:0], f_mirrored};
        end
    end

    // Bounds stage: shortest and longest length, pair products of lengths,
    // and the tests that need no row products.
    logic [W-1:0]   lo;
    logic [W-1:0]   hi;
    logic [NW-1:0]  tol_lo;
    logic [XW-1:0]  l0x;
    logic [XW-1:0]  onex;
    logic [XW-1:0]  dev;

    always_comb begin
        lo = len[0];
        hi = len[0];
        for (int r = 1; r < 3; r++) begin
            if (len[r] < lo) begin
                lo = len[r];
            end
            if (len[r] > hi) begin
                hi = len[r];
            end
        end
        tol_lo = tol_reg * lo;
        l0x    = XW'(len[0]);
        onex   = XW'(1) << FB;
        dev    = (l0x > onex) ? (l0x - onex) : (onex - l0x);
    end

    logic [W-1:0]   lo_e_reg;
    logic [W-1:0]   hi_e_reg;
    logic [2*W-1:0] lab_e_reg [3];
    logic [2*W-1:0] dot_e_reg [3];
    logic           degen_e_reg;
    logic           nonuni_e_reg;
    logic           unif_e_reg;
    logic           sat_e_reg;
    logic           pres_e_reg;
    logic           mir_e_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            lo_e_reg     <= lo;
            hi_e_reg     <= hi;
            lab_e_reg[0] <= len[0] * len[1];
            lab_e_reg[1] <= len[0] * len[2];
            lab_e_reg[2] <= len[1] * len[2];
            dot_e_reg    <= dot_dly_reg[W-1];
            degen_e_reg  <= (DGW'(lo) << TOL_W) < (DGW'(tol_reg) << FB);
            nonuni_e_reg <= (NW'(hi - lo) << TOL_W) > tol_lo;
            unif_e_reg   <= (UW'(dev) << TOL_W) > (UW'(tol_reg) << FB);
            sat_e_reg    <= SW'(hi) >= (SW'(lo) << RATIO_FRAC);
            pres_e_reg   <= pres_dly_reg[W-1];
            mir_e_reg    <= mir_dly_reg[W-1];
        end
    end

    // Scale ratio, started from the bounds stage.
    logic [QBITS-1:0] quot;

    wmnc_div #(.W(W)) u_div (
        .aclk    (aclk),
        .ce      (ce),
        .in_hi   (hi_e_reg),
        .in_lo   (lo_e_reg),
        .out_quot(quot)
    );

    // Class stage: the skew tests weigh each dot product against the
    // tolerance times the two row lengths; the first test that hits wins.
    logic [SKW-1:0] skew_rhs [3];
    logic [2:0]     skew;
    wmnc_status_t   st_next;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            skew_rhs[p] = tol_reg * lab_e_reg[p];
            skew[p]     = (SKW'(dot_e_reg[p]) << TOL_W) > skew_rhs[p];
        end
        st_next.present  = pres_e_reg;
        st_next.mirrored = mir_e_reg;
        st_next.saturate = sat_e_reg;
        if (degen_e_reg) begin
            st_next.world_class = CLS_DEGENERATE;
        end else if (|skew) begin
            st_next.world_class = CLS_SKEW;
        end else if (nonuni_e_reg) begin
            st_next.world_class = CLS_NONUNIFORM;
        end else if (unif_e_reg) begin
            st_next.world_class = CLS_UNIFORM;
        end else begin
            st_next.world_class = CLS_UNIT;
        end
    end

    // The status word rides beside the divider until the quotient is ready.
    wmnc_status_t st_reg [QBITS];

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg[0] <= st_next;
            for (int d = 1; d < QBITS; d++) begin
                st_reg[d] <= st_reg[d-1];
            end
        end
    end

    // Output register. An absent matrix reads as identity.
    wmnc_status_t       st_out;
    wmnc_class_t        cls_next;
    logic               mir_next;
    logic [RATIO_W-1:0] ratio_next;
    wmnc_class_t        out_cls_reg;
    logic               out_mir_reg;
    logic               out_pres_reg;
    logic [RATIO_W-1:0] out_ratio_reg;

    always_comb begin
        st_out = st_reg[QBITS-1];
        if (!st_out.present) begin
            cls_next   = CLS_UNIT;
            mir_next   = 1'b0;
            ratio_next = RATIO_ONE;
        end else begin
            cls_next = st_out.world_class;
            mir_next = st_out.mirrored;
            if (st_out.world_class != CLS_NONUNIFORM) begin
                ratio_next = RATIO_ONE;
            end else if (st_out.saturate) begin
                ratio_next = RATIO_MAX;
            end else begin
                ratio_next = quot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_cls_reg   <= cls_next;
            out_mir_reg   <= mir_next;
            out_pres_reg  <= st_out.present;
            out_ratio_reg <= ratio_next;
        end
    end

    assign m_tdata = {OUT_PAD_W'(0), out_ratio_reg, out_mir_reg, out_cls_reg};

    // Checks.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ratio_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_cls_reg != CLS_NONUNIFORM |-> out_ratio_reg == RATIO_ONE)
        else $error("ratio not 1.0 outside the nonuniform class");

    a_absent_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_pres_reg |-> out_cls_reg == CLS_UNIT && !out_mir_reg)
        else $error("absent matrix not reported as identity");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
